@@ hdl/url_percent_encoder_macros.svh @@
// Assertion macros for the url_percent_encoder port checker.
`ifndef URL_PERCENT_ENCODER_MACROS_SVH
`define URL_PERCENT_ENCODER_MACROS_SVH

// Same-cycle implication, off while rst is high.
`define UPE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url_percent_encoder port check failed");

// Next-cycle implication, off while rst is high.
`define UPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url_percent_encoder port check failed");

// Next-cycle implication that also covers the reset cycles.
`define UPE_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("url_percent_encoder port check failed");

`endif

@@ hdl/upe_pkg.sv @@
// Shared types, constants and character-class functions of the URL percent encoder.
package upe_pkg;

  localparam int ByteW   = 8;
  localparam int MaskW   = 18;
  localparam int MaxRes  = 7;
  localparam int CntW    = 3;
  localparam int CfgIdxW = 2;

  localparam logic [ByteW-1:0] PctChar = 8'h25;

  // Reserved characters, entry 0 first: : / ? # [ ] @ ! $ & ' ( ) * + , ; =
  localparam logic [MaskW-1:0][ByteW-1:0] ReservedChars = {
    8'h3D, 8'h3B, 8'h2C, 8'h2B, 8'h2A, 8'h29, 8'h28, 8'h27, 8'h26,
    8'h24, 8'h21, 8'h40, 8'h5D, 8'h5B, 8'h23, 8'h3F, 8'h2F, 8'h3A
  };

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAFE_MASK    = 2'd0,
    REG_ENCODED_MODE = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    HOLD_NONE = 3'b001,
    HOLD_PCT  = 3'b010,
    HOLD_DIG  = 3'b100
  } hold_t;

  typedef struct packed {
    logic [MaskW-1:0] safe_mask;
    logic             encoded_mode;
  } cfg_t;

  typedef struct packed {
    logic [MaxRes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              count;
    logic                         last;
  } expand_t;

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] d);
    logic [ByteW-1:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'h0, d};
    end else begin
      c = 8'h37 + {4'h0, d};
    end
    return c;
  endfunction

  function automatic logic is_hex(input logic [ByteW-1:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic is_unreserved(input logic [ByteW-1:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2E || b == 8'h7E ||
           b == 8'h5F || b == 8'h2D;
  endfunction

  // One-hot hit vector over the reserved set; zero if b is not reserved.
  function automatic logic [MaskW-1:0] reserved_sel(input logic [ByteW-1:0] b);
    logic [MaskW-1:0] sel;
    for (int i = 0; i < MaskW; i++) begin
      sel[i] = (b == ReservedChars[i]);
    end
    return sel;
  endfunction

endpackage

@@ hdl/upe_if.sv @@
// Valid/ready channel interfaces: input bytes, encoded bytes, register writes.
interface upe_in_if;
  logic                     valid;
  logic                     ready;
  logic [upe_pkg::ByteW-1:0] data_byte;
  logic                     in_last;

  modport source (output valid, output data_byte, output in_last, input ready);
  modport sink   (input valid, input data_byte, input in_last, output ready);
endinterface

interface upe_out_if;
  logic                     valid;
  logic                     ready;
  logic [upe_pkg::ByteW-1:0] out_byte;
  logic                     run_end;
  logic                     string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

interface upe_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [upe_pkg::CfgIdxW-1:0] index;
  logic [upe_pkg::MaskW-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/upe_cfg_regs.sv @@
// Configuration registers: safe mask and encoded-mode flag.
module upe_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  upe_cfg_if.sink         cfg,
  output upe_pkg::cfg_t   regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.safe_mask    <= '0;
      regs.encoded_mode <= 1'b0;
    end else if (cfg.valid) begin
      if (cfg.index == upe_pkg::REG_SAFE_MASK) begin
        regs.safe_mask <= cfg.data;
      end else if (cfg.index == upe_pkg::REG_ENCODED_MODE) begin
        regs.encoded_mode <= cfg.data[0];
      end
    end
  end

endmodule

@@ hdl/upe_expand.sv @@
// Expands one input byte into its run of up to seven result bytes; holds lookahead state.
module upe_expand (
  input  logic                      clk,
  input  logic                      rst,
  input  upe_pkg::cfg_t             regs,
  input  logic [upe_pkg::ByteW-1:0] data_byte,
  input  logic                      in_last,
  input  logic                      take,
  output upe_pkg::expand_t          run
);

  upe_pkg::hold_t            hold;
  upe_pkg::hold_t            hold_next;
  logic [upe_pkg::ByteW-1:0] digit;

  logic                      fr_hold;
  logic                      fr_esc;
  logic                      plain;
  logic                      use_fresh;
  logic [upe_pkg::CntW-1:0]  fr_n;
  logic [upe_pkg::CntW-1:0]  pre_n;
  logic [upe_pkg::ByteW-1:0] fr  [3];
  logic [upe_pkg::ByteW-1:0] pre [4];

  // Byte taken afresh: pass, escape, or start a held percent.
  always_comb begin
    plain   = upe_pkg::is_unreserved(data_byte) ||
              (|(upe_pkg::reserved_sel(data_byte) & regs.safe_mask));
    fr_hold = regs.encoded_mode && data_byte == upe_pkg::PctChar && !in_last;
    fr_esc  = !fr_hold && !plain;
    if (fr_hold) begin
      fr_n = 3'd0;
    end else if (fr_esc) begin
      fr_n = 3'd3;
    end else begin
      fr_n = 3'd1;
    end
    if (fr_esc) begin
      fr[0] = upe_pkg::PctChar;
      fr[1] = upe_pkg::hex_char(data_byte[7:4]);
      fr[2] = upe_pkg::hex_char(data_byte[3:0]);
    end else begin
      fr[0] = data_byte;
      fr[1] = data_byte;
      fr[2] = data_byte;
    end
  end

  // Resolve held bytes, then pick the prefix in front of the fresh part.
  always_comb begin
    pre[0]    = upe_pkg::PctChar;
    pre[1]    = upe_pkg::hex_char(upe_pkg::PctChar[7:4]);
    pre[2]    = upe_pkg::hex_char(upe_pkg::PctChar[3:0]);
    pre[3]    = digit;
    pre_n     = 3'd0;
    use_fresh = 1'b1;
    hold_next = upe_pkg::HOLD_NONE;
    case (hold)
      upe_pkg::HOLD_PCT: begin
        if (upe_pkg::is_hex(data_byte) && !in_last) begin
          use_fresh = 1'b0;
          hold_next = upe_pkg::HOLD_DIG;
        end else begin
          pre_n = 3'd3;
        end
      end
      upe_pkg::HOLD_DIG: begin
        if (upe_pkg::is_hex(data_byte)) begin
          pre[1]    = digit;
          pre[2]    = data_byte;
          pre_n     = 3'd3;
          use_fresh = 1'b0;
        end else begin
          pre_n = 3'd4;
        end
      end
      default: begin
        pre_n = 3'd0;
      end
    endcase
    if (use_fresh && fr_hold) begin
      hold_next = upe_pkg::HOLD_PCT;
    end
  end

  always_comb begin
    logic [upe_pkg::CntW-1:0] j;
    for (int i = 0; i < upe_pkg::MaxRes; i++) begin
      j = upe_pkg::CntW'(i) - pre_n;
      if (upe_pkg::CntW'(i) < pre_n) begin
        run.bytes[i] = pre[2'(i)];
      end else if (j < 3'd3) begin
        run.bytes[i] = fr[j[1:0]];
      end else begin
        run.bytes[i] = '0;
      end
    end
    run.count = pre_n + (use_fresh ? fr_n : 3'd0);
    run.last  = in_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= upe_pkg::HOLD_NONE;
    end else if (take) begin
      hold <= hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && hold == upe_pkg::HOLD_PCT) begin
      digit <= data_byte;
    end
  end

endmodule

@@ hdl/upe_serial.sv @@
// Run register that shifts result bytes out one per beat into the output register.
module upe_serial (
  input  logic                      clk,
  input  logic                      rst,
  input  upe_pkg::expand_t          run,
  input  logic                      take,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [upe_pkg::ByteW-1:0] out_byte,
  output logic                      run_end,
  output logic                      string_end
);

  logic [upe_pkg::ByteW-1:0] pend [upe_pkg::MaxRes];
  logic [upe_pkg::CntW-1:0]  rem;
  logic                      str_last;
  logic                      out_load;

  assign out_load = (rem != '0) && (!out_valid || out_ready);
  assign in_ready = (rem == '0) || (rem == upe_pkg::CntW'(1) && out_load);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        rem <= run.count;
      end else if (out_load) begin
        rem <= rem - upe_pkg::CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte   <= pend[0];
      run_end    <= (rem == upe_pkg::CntW'(1));
      string_end <= (rem == upe_pkg::CntW'(1)) && str_last;
    end
    if (take) begin
      for (int i = 0; i < upe_pkg::MaxRes; i++) begin
        pend[i] <= run.bytes[i];
      end
      str_last <= run.last;
    end else if (out_load) begin
      for (int i = 0; i < upe_pkg::MaxRes - 1; i++) begin
        pend[i] <= pend[i+1];
      end
    end
  end

endmodule

@@ hdl/url_percent_encoder.sv @@
// Top level of the URL percent encoder.
//
// Channels (valid/ready, a beat moves when both are high at a rising clk edge):
//   raw : input string, one byte per beat (data_byte, in_last on the final byte).
//   enc : encoded string, one byte per beat; run_end marks the last byte caused
//         by one input beat, string_end the final byte of the whole string.
//   cfg : register writes; index 0 = safe_mask, 1 = encoded_mode. Always ready.
//         Write only while the block is drained.
// The first result byte of an input beat passes through the run register and then
// the output register. A passed byte gives one result byte, an escaped byte three,
// a failed lookahead up to seven; a held % or digit gives no output. The one-byte
// output register sets the input rate. The next input beat is taken in the same
// cycle the previous run's last byte moves into the output register.
// Reset (rst, synchronous): clears held lookahead bytes, pending results and
// registers; nothing needs to be swept.
// Receiver stall: enc holds its beat; the run register keeps the rest of the
// run; raw.ready stays low until the last byte enters the output register.
module url_percent_encoder (
  input  logic       clk,
  input  logic       rst,
  upe_in_if.sink     raw,
  upe_out_if.source  enc,
  upe_cfg_if.sink    cfg
);

  upe_pkg::cfg_t    regs;
  upe_pkg::expand_t run;
  logic             take;

  assign take = raw.valid && raw.ready;

  upe_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Byte classification and lookahead state; produces the whole run.
  upe_expand u_expand (
    .clk       (clk),
    .rst       (rst),
    .regs      (regs),
    .data_byte (raw.data_byte),
    .in_last   (raw.in_last),
    .take      (take),
    .run       (run)
  );

  // Run register and output register.
  upe_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .run        (run),
    .take       (take),
    .in_ready   (raw.ready),
    .out_valid  (enc.valid),
    .out_ready  (enc.ready),
    .out_byte   (enc.out_byte),
    .run_end    (enc.run_end),
    .string_end (enc.string_end)
  );

endmodule

@@ hdl/upe_chk.sv @@
// Port-level checker for the URL percent encoder, bound to the top level.
`include "url_percent_encoder_macros.svh"

module upe_chk (
  input logic                      clk,
  input logic                      rst,
  input logic                      raw_ready,
  input logic                      enc_valid,
  input logic                      enc_ready,
  input logic [upe_pkg::ByteW-1:0] out_byte,
  input logic                      run_end,
  input logic                      string_end
);

  `UPE_ASSERT_NEXT(a_out_hold, enc_valid && !enc_ready, enc_valid)
  `UPE_ASSERT_NEXT(a_out_stable, enc_valid && !enc_ready, $stable(out_byte) && $stable(run_end) && $stable(string_end))
  `UPE_ASSERT_NOW(a_end_in_run, enc_valid && string_end, run_end)
  `UPE_ASSERT_NEXT(a_busy_drives, !raw_ready, enc_valid)
  `UPE_ASSERT_ALWAYS(a_reset_quiet, rst, !enc_valid)

endmodule

bind url_percent_encoder upe_chk u_upe_chk (
  .clk        (clk),
  .rst        (rst),
  .raw_ready  (raw.ready),
  .enc_valid  (enc.valid),
  .enc_ready  (enc.ready),
  .out_byte   (enc.out_byte),
  .run_end    (enc.run_end),
  .string_end (enc.string_end)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for url_percent_encoder: directed table, then random strings.
module tb;

  // Run limit, far above the slowest legal run: ~310 beats, each up to 7 result
  // beats behind the slowest receiver pattern, plus sender gaps and drains.
  localparam int unsigned LIMIT_CYCLES = 400000;
  // Idle cycles after the last result before a register write; a held '%' or
  // digit makes no result, so the block may still be settling.
  localparam int unsigned DRAIN_WAIT = 10;
  localparam int unsigned TAIL_WAIT = 20;
  // Random beats per configuration setting; six settings give ~285 beats.
  localparam int unsigned PHASE_BEATS = 44;
  localparam int unsigned NUM_PHASES = 6;
  // Marks a table row whose result bytes come from the encoder model.
  localparam logic [3:0] PREDICTED = 4'hF;

  // Character sets, right-aligned; char_at() picks entry i counting from the left.
  localparam logic [66*8-1:0] UNRES_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.~_-";
  localparam logic [66*8-1:0] HEX_CHARS = "0123456789ABCDEFabcdef";
  localparam logic [66*8-1:0] RESV_CHARS = ":/?#[]@!$&'()*+,;=";
  localparam logic [66*8-1:0] HEX_UPPER = "0123456789ABCDEF";

  typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

  // One row of the directed table: either an input beat or a register write.
  // n_typed/typed hold result bytes typed in by hand (right-aligned string).
  typedef struct packed {
    row_kind_t                 kind;
    upe_pkg::cfg_reg_t         reg_idx;
    logic [upe_pkg::MaskW-1:0] value;
    logic [upe_pkg::ByteW-1:0] data;
    logic                      last;
    logic [3:0]                n_typed;
    logic [55:0]               typed;
  } stim_row_t;

  // One beat on the encoded-output channel.
  typedef struct packed {
    logic [upe_pkg::ByteW-1:0] ch;
    logic                      run_end;
    logic                      string_end;
  } enc_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  upe_in_if  raw_ch ();
  upe_out_if enc_ch ();
  upe_cfg_if cfg_ch ();

  url_percent_encoder DUT (
    .clk (clk),
    .rst (rst),
    .raw (raw_ch),
    .enc (enc_ch),
    .cfg (cfg_ch)
  );

  // Encoder model state: register copies and the held lookahead bytes.
  logic [upe_pkg::MaskW-1:0] safe_mask_m;
  logic                      enc_mode_m;
  int unsigned               held_m;   // 0 nothing, 1 '%' held, 2 '%' and a digit held
  logic [upe_pkg::ByteW-1:0] held_digit_m;

  logic [upe_pkg::ByteW-1:0] run_q[$];          // bytes caused by the beat being modeled
  enc_beat_t                 pending_enc_q[$];  // encoded beats still to come from the DUT
  stim_row_t                 stim_tab[$];
  logic [upe_pkg::ByteW-1:0] str_q[$];

  enc_beat_t   got_beat;
  enc_beat_t   want_beat;
  int unsigned errors;
  int unsigned burst_left;
  int unsigned beats_in_phase;
  int unsigned cycle_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [upe_pkg::ByteW-1:0] char_at(input logic [66*8-1:0] s,
                                                        input int len, input int i);
    return s[(len-1-i)*8 +: 8];
  endfunction

  function automatic logic hex_digit(input logic [upe_pkg::ByteW-1:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  function automatic logic [upe_pkg::ByteW-1:0] rand_hex();
    return char_at(HEX_CHARS, 22, int'($urandom_range(0, 21)));
  endfunction

  task automatic put_escaped(input logic [upe_pkg::ByteW-1:0] b);
    run_q.insert(run_q.size(), upe_pkg::PctChar);
    run_q.insert(run_q.size(), char_at(HEX_UPPER, 16, int'(b[7:4])));
    run_q.insert(run_q.size(), char_at(HEX_UPPER, 16, int'(b[3:0])));
  endtask

  // A byte with nothing held: pass, escape, or start holding a '%'.
  task automatic fresh_byte(input logic [upe_pkg::ByteW-1:0] b, input logic last);
    logic plain;
    plain = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9") ||
            b == "." || b == "~" || b == "_" || b == "-";
    for (int i = 0; i < upe_pkg::MaskW; i++) begin
      if (b == char_at(RESV_CHARS, upe_pkg::MaskW, i)) plain = safe_mask_m[i];
    end
    if (enc_mode_m && b == upe_pkg::PctChar) begin
      if (last) put_escaped(b);
      else held_m = 1;
    end else if (plain) begin
      run_q.insert(run_q.size(), b);
    end else begin
      put_escaped(b);
    end
  endtask

  // Encoder model: fills run_q with the bytes one input beat causes.
  // Held bytes resolve by the lookahead rules whatever the current mode.
  task automatic encode_byte(input logic [upe_pkg::ByteW-1:0] b, input logic last);
    int unsigned was_held;
    was_held = held_m;
    held_m = 0;
    run_q.delete();
    case (was_held)
      1: begin
        if (hex_digit(b) && !last) begin
          held_m = 2;
          held_digit_m = b;
        end else begin
          // lookahead failed or the string ended: '%' goes out as %25
          put_escaped(upe_pkg::PctChar);
          fresh_byte(b, last);
        end
      end
      2: begin
        if (hex_digit(b)) begin
          run_q.insert(run_q.size(), upe_pkg::PctChar);
          run_q.insert(run_q.size(), held_digit_m);
          run_q.insert(run_q.size(), b);
        end else begin
          put_escaped(upe_pkg::PctChar);
          run_q.insert(run_q.size(), held_digit_m);
          fresh_byte(b, last);
        end
      end
      default: fresh_byte(b, last);
    endcase
  endtask

  // Drive one input beat. The sender runs in bursts with random gaps between
  // them, gap 0 included, so some stretches see no idling at all.
  task automatic send_beat(input logic [upe_pkg::ByteW-1:0] b, input logic last,
                           input logic [3:0] n_typed, input logic [55:0] typed);
    int unsigned gap;
    int          nt;
    enc_beat_t   e;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(0, 3))
        0:       gap = 0;
        1, 2:    gap = $urandom_range(1, 4);
        default: gap = $urandom_range(5, 20);
      endcase
      if (gap != 0) begin
        raw_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    raw_ch.valid     <= 1'b1;
    raw_ch.data_byte <= b;
    raw_ch.in_last   <= last;
    do @(posedge clk); while (!raw_ch.ready);
    // beat taken at this edge
    encode_byte(b, last);
    if (n_typed != PREDICTED) begin
      nt = int'(n_typed);
      run_q.delete();
      for (int k = 0; k < nt; k++) run_q.insert(run_q.size(), typed[(nt-1-k)*8 +: 8]);
    end
    for (int k = 0; k < run_q.size(); k++) begin
      e.ch         = run_q[k];
      e.run_end    = (k == run_q.size() - 1);
      e.string_end = last && (k == run_q.size() - 1);
      pending_enc_q.insert(pending_enc_q.size(), e);
    end
  endtask

  // Stop sending, wait for every encoded beat, then let the block settle.
  task automatic wait_drained(input int unsigned extra);
    raw_ch.valid <= 1'b0;
    while (pending_enc_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Register write, only with the block drained. Held lookahead bytes may
  // stay held across it.
  task automatic write_reg(input upe_pkg::cfg_reg_t idx,
                           input logic [upe_pkg::MaskW-1:0] val);
    wait_drained(DRAIN_WAIT);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      upe_pkg::REG_SAFE_MASK:    safe_mask_m = val;
      upe_pkg::REG_ENCODED_MODE: enc_mode_m = val[0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_beat(input logic [upe_pkg::ByteW-1:0] b, input logic last,
                          input logic [3:0] n_typed, input logic [55:0] typed);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_BEAT;
    r.data    = b;
    r.last    = last;
    r.n_typed = n_typed;
    r.typed   = typed;
    stim_tab.insert(stim_tab.size(), r);
  endtask

  task automatic add_write(input upe_pkg::cfg_reg_t idx,
                           input logic [upe_pkg::MaskW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.value   = val;
    stim_tab.insert(stim_tab.size(), r);
  endtask

  // Receiver: ready follows a pattern picked anew for each random span: always
  // ready, coin flip, one cycle in four, or low two thirds and high one third.
  initial begin
    int unsigned stall_kind;
    int unsigned span;
    enc_ch.ready <= 1'b0;
    forever begin
      stall_kind = $urandom_range(0, 3);
      span = $urandom_range(30, 150);
      for (int unsigned n = 0; n < span; n++) begin
        @(posedge clk);
        case (stall_kind)
          0:       enc_ch.ready <= 1'b1;
          1:       enc_ch.ready <= 1'($urandom_range(0, 1));
          2:       enc_ch.ready <= (n % 4 == 0);
          default: enc_ch.ready <= (n % 12 >= 8);
        endcase
      end
    end
  end

  // Output check: every encoded beat against the oldest pending one.
  always @(posedge clk) begin
    if (!rst && enc_ch.valid && enc_ch.ready) begin
      got_beat.ch         = enc_ch.out_byte;
      got_beat.run_end    = enc_ch.run_end;
      got_beat.string_end = enc_ch.string_end;
      if (pending_enc_q.size() == 0) begin
        errors++;
        $display("%0t: enc beat with none expected: got byte %h run_end %b string_end %b",
                 $time, got_beat.ch, got_beat.run_end, got_beat.string_end);
      end else begin
        want_beat = pending_enc_q.pop_front();
        if (got_beat != want_beat) begin
          errors++;
          $display("%0t: enc beat mismatch: expected byte %h run_end %b string_end %b, %s",
                   $time, want_beat.ch, want_beat.run_end, want_beat.string_end,
                   $sformatf("got byte %h run_end %b string_end %b",
                             got_beat.ch, got_beat.run_end, got_beat.string_end));
        end
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("url_percent_encoder regression: fail");
    $finish;
  end

  initial begin
    logic [upe_pkg::MaskW-1:0] mask_v;
    logic                      mode_v;
    int unsigned               i;

    raw_ch.valid     <= 1'b0;
    raw_ch.data_byte <= '0;
    raw_ch.in_last   <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= upe_pkg::REG_SAFE_MASK;
    cfg_ch.data      <= '0;
    safe_mask_m  = '0;
    enc_mode_m   = 1'b0;
    held_m       = 0;
    held_digit_m = '0;
    errors       = 0;
    burst_left   = 0;

    // Directed table. Reset settings first: nothing reserved is safe, no
    // triplet pass-through; byte extremes and a lone '%' on the last byte.
    add_beat(8'h00, 1'b0, 4'd3, "%00");
    add_beat(8'hFF, 1'b0, 4'd3, "%FF");
    add_beat("~",   1'b0, 4'd1, "~");
    add_beat(":",   1'b0, 4'd3, "%3A");
    add_beat("%",   1'b1, 4'd3, "%25");
    // Other extreme: every reserved char safe, encoded mode on.
    add_write(upe_pkg::REG_SAFE_MASK, '1);
    add_write(upe_pkg::REG_ENCODED_MODE, 18'd1);
    add_beat(":",   1'b0, 4'd1, ":");
    add_beat(8'h20, 1'b0, 4'd3, "%20");
    // good triplet: two silent beats, then all three bytes
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("4", 1'b0, PREDICTED, '0);
    add_beat("1", 1'b0, PREDICTED, '0);
    // lookahead fails after the digit
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("a", 1'b0, PREDICTED, '0);
    add_beat("z", 1'b0, PREDICTED, '0);
    // lookahead fails on a new '%', which is itself escaped as the last byte
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("%", 1'b1, PREDICTED, '0);
    // string ends with only '%' and a digit seen
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("7", 1'b1, PREDICTED, '0);
    // failed lookahead plus an escaped byte: the longest run
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("4", 1'b0, PREDICTED, '0);
    add_beat(8'h20, 1'b0, PREDICTED, '0);
    // mixed-case triplet closing the string
    add_beat("%", 1'b0, PREDICTED, '0);
    add_beat("F", 1'b0, PREDICTED, '0);
    add_beat("f", 1'b1, PREDICTED, '0);
    // mode drops while a '%' is held; the held '%' still resolves as a triplet
    add_beat("%", 1'b0, PREDICTED, '0);
    add_write(upe_pkg::REG_ENCODED_MODE, 18'd0);
    add_beat("4", 1'b0, PREDICTED, '0);
    add_beat("1", 1'b1, PREDICTED, '0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_tab[r]) begin
      if (stim_tab[r].kind == ROW_WRITE) begin
        write_reg(stim_tab[r].reg_idx, stim_tab[r].value);
      end else begin
        send_beat(stim_tab[r].data, stim_tab[r].last, stim_tab[r].n_typed,
                  stim_tab[r].typed);
      end
    end

    // Random strings under several settings, extremes among them.
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       begin mask_v = 18'($urandom); mode_v = 1'b0; end
        1:       begin mask_v = '1;            mode_v = 1'b1; end
        2:       begin mask_v = '0;            mode_v = 1'b1; end
        3:       begin mask_v = 18'($urandom); mode_v = 1'b1; end
        4:       begin mask_v = '1;            mode_v = 1'b0; end
        default: begin mask_v = 18'($urandom); mode_v = 1'($urandom_range(0, 1)); end
      endcase
      write_reg(upe_pkg::REG_SAFE_MASK, mask_v);
      write_reg(upe_pkg::REG_ENCODED_MODE, {17'd0, mode_v});
      beats_in_phase = 0;
      while (beats_in_phase < PHASE_BEATS) begin
        // A string is a handful of tokens; most are well formed (plain chars,
        // good triplets), the rest broken triplets and arbitrary bytes. The
        // last byte may land inside a triplet.
        str_q.delete();
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: begin
              str_q.insert(str_q.size(),
                           char_at(UNRES_CHARS, 66, int'($urandom_range(0, 65))));
            end
            5, 6: begin
              str_q.insert(str_q.size(),
                           char_at(RESV_CHARS, upe_pkg::MaskW,
                                   int'($urandom_range(0, 17))));
            end
            7, 8: begin
              str_q.insert(str_q.size(), upe_pkg::PctChar);
              str_q.insert(str_q.size(), rand_hex());
              str_q.insert(str_q.size(), rand_hex());
            end
            9: begin
              str_q.insert(str_q.size(), upe_pkg::PctChar);
              str_q.insert(str_q.size(), rand_hex());
              str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            end
            10: begin
              str_q.insert(str_q.size(), upe_pkg::PctChar);
              str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            end
            11:     str_q.insert(str_q.size(), upe_pkg::PctChar);
            12, 13: str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
            14:     str_q.insert(str_q.size(), rand_hex());
            default: begin
              if ($urandom_range(0, 1) != 0) begin
                str_q.insert(str_q.size(), 8'($urandom_range(0, 32)));
              end else begin
                str_q.insert(str_q.size(), 8'($urandom_range(127, 255)));
              end
            end
          endcase
        end
        for (i = 0; i < str_q.size(); i++) begin
          send_beat(str_q[i], (i == str_q.size() - 1), PREDICTED, '0);
        end
        beats_in_phase += str_q.size();
      end
      // Sometimes send a '%' that, in encoded mode, stays held across the next register writes.
      if (phase != NUM_PHASES - 1 && $urandom_range(0, 2) == 0) begin
        send_beat(upe_pkg::PctChar, 1'b0, PREDICTED, '0);
      end
    end

    wait_drained(TAIL_WAIT);
    if (errors == 0) begin
      $display("url_percent_encoder regression: pass");
    end else begin
      $display("url_percent_encoder regression: fail");
    end
    $finish;
  end

endmodule
